@@ sv/sorb_pkg.sv @@
// Shared types and constants for the sequenced overwriting ring buffer.
package sorb_pkg;

	// Width of a sequence number and its saturation value.
	localparam int SEQ_W = 63;
	localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

	// Request kind carried in the input tuser bit.
	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_READ  = 1'b1
	} kind_t;

endpackage

@@ sv/sequenced_overwrite_ring_buffer_top.sv @@
// Sequenced overwriting ring buffer: ring store, sequence tagging and read scan sequencer.
//
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tuser: kind; tdata: write_data, read_seqno
// m_*       out        m_tvalid/m_tready  tuser: found; tdata: read_data, next_seqno
//
// A write request is stored at the edge that accepts it, and the block stays ready.
// A read scans one entry per cycle with one comparator, then passes a drain step and a
// final step that loads the result; the next request is accepted once the block is idle again.
// Reset clears the pointer and the fill count and sets the sequence counter to 1; entries at or
// above the fill count are empty, so the memories are never cleared. A waiting result does not
// block writes; a following read holds in its last step until the output register drains.
module sequenced_overwrite_ring_buffer_top #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// Bits from lowest: write_data (DATA_WIDTH), read_seqno (63), zero fill.
	input  logic [((DATA_WIDTH + sorb_pkg::SEQ_W + 7) / 8) * 8 - 1:0] s_tdata,
	// Bit 0: kind (0 = write, 1 = read).
	input  logic [0:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// Bits from lowest: read_data (DATA_WIDTH), next_seqno (63), zero fill.
	output logic [((DATA_WIDTH + sorb_pkg::SEQ_W + 7) / 8) * 8 - 1:0] m_tdata,
	// Bit 0: found.
	output logic [0:0] m_tuser
);
	import sorb_pkg::*;

	localparam int TDATA_W = ((DATA_WIDTH + SEQ_W + 7) / 8) * 8;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	state_t state_q;

	// Ring memories. Entries are only meaningful below the fill count.
	logic [SEQ_W-1:0]      tag_mem  [DEPTH];
	logic [DATA_WIDTH-1:0] word_mem [DEPTH];

	logic [IDX_W-1:0]      wp_q;
	logic [SEQ_W-1:0]      seq_q;
	logic [CNT_W-1:0]      fill_q;
	logic [IDX_W-1:0]      idx_q;

	// Scan pipeline: memory read data and the index it came from.
	logic                  v_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [SEQ_W-1:0]      tag_rd_s1;
	logic [DATA_WIDTH-1:0] word_rd_s1;

	logic [SEQ_W-1:0]      want_q;
	logic                  have_q;
	logic                  exact_q;
	logic [SEQ_W-1:0]      best_tag_q;
	logic [DATA_WIDTH-1:0] best_word_q;

	logic                  out_valid_q;
	logic                  out_found_q;
	logic [DATA_WIDTH-1:0] out_data_q;
	logic [SEQ_W-1:0]      out_seq_q;

	logic                  accept;
	logic                  wr_en;
	logic                  rd_start;
	logic                  ent_ok;
	logic                  take_hit;
	logic                  take_more;
	logic                  out_free;
	logic                  load_out;
	logic [DATA_WIDTH-1:0] in_data;
	logic [SEQ_W-1:0]      in_seq;
	logic [SEQ_W-1:0]      next_seq;

	assign in_data  = s_tdata[DATA_WIDTH-1:0];
	assign in_seq   = s_tdata[DATA_WIDTH +: SEQ_W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign wr_en    = accept && (s_tuser[0] == KIND_WRITE);
	assign rd_start = accept && (s_tuser[0] == KIND_READ);

	// The compare unit looks at one entry per cycle. An exact match locks the choice;
	// otherwise the smallest tag above the request wins, the first one seen on ties.
	assign ent_ok    = v_s1 && (CNT_W'(idx_s1) < fill_q) && !exact_q;
	assign take_hit  = ent_ok && (want_q != '0) && (tag_rd_s1 == want_q);
	assign take_more = ent_ok && !take_hit && (tag_rd_s1 > want_q)
		&& (!have_q || (tag_rd_s1 < best_tag_q));

	assign next_seq = (best_tag_q == SEQ_MAX) ? SEQ_MAX : best_tag_q + 1'b1;
	assign out_free = !out_valid_q || m_tready;
	assign load_out = (state_q == ST_FIN) && out_free;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = TDATA_W'({out_seq_q, out_data_q});

	// Memory write on an accepted write request, registered read at the scan index.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_mem[wp_q]  <= seq_q;
			word_mem[wp_q] <= in_data;
		end
		tag_rd_s1  <= tag_mem[idx_q];
		word_rd_s1 <= word_mem[idx_q];
	end

	// Datapath registers of the scan.
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (rd_start) begin
			want_q <= in_seq;
		end
		if (take_hit || take_more) begin
			best_tag_q  <= tag_rd_s1;
			best_word_q <= word_rd_s1;
		end
	end

	// Sequencer, ring control and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			seq_q       <= SEQ_W'(1);
			fill_q      <= '0;
			idx_q       <= '0;
			v_s1        <= 1'b0;
			have_q      <= 1'b0;
			exact_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_data_q  <= '0;
			out_seq_q   <= '0;
		end else begin
			v_s1 <= (state_q == ST_SCAN);
			// A new result replaces the one leaving in the same cycle.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (take_hit) begin
				have_q  <= 1'b1;
				exact_q <= 1'b1;
			end else if (take_more) begin
				have_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (wr_en) begin
						wp_q <= (wp_q == IDX_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
						if (seq_q != SEQ_MAX) begin
							seq_q <= seq_q + 1'b1;
						end
						if (fill_q != CNT_W'(DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
					end
					if (rd_start) begin
						idx_q   <= '0;
						have_q  <= 1'b0;
						exact_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == IDX_W'(DEPTH - 1)) begin
						idx_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_found_q <= have_q;
						out_data_q  <= have_q ? best_word_q : '0;
						out_seq_q   <= have_q ? next_seq : want_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/sorb_checker.sv @@
// Port-level checks for the sequenced overwriting ring buffer, with its bind.
module sorb_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	// Bits from lowest: write_data, read_seqno, zero fill.
	input logic [((DATA_WIDTH + sorb_pkg::SEQ_W + 7) / 8) * 8 - 1:0] s_tdata,
	// Bit 0: kind.
	input logic [0:0] s_tuser,
	input logic m_tvalid,
	input logic m_tready,
	// Bits from lowest: read_data, next_seqno, zero fill.
	input logic [((DATA_WIDTH + sorb_pkg::SEQ_W + 7) / 8) * 8 - 1:0] m_tdata,
	// Bit 0: found.
	input logic [0:0] m_tuser
);
	import sorb_pkg::*;

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A miss returns a zero data word.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[DATA_WIDTH-1:0] == '0)
		else $error("miss with nonzero data");

	// A hit always points at a real next sequence number.
	a_hit_next: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[DATA_WIDTH +: SEQ_W] != '0)
		else $error("hit with zero next sequence number");

	// A write request never produces a result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] == KIND_WRITE |=> !$rose(m_tvalid))
		else $error("result after a write request");

	// A read request occupies the block while it scans.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] == KIND_READ |=> !s_tready)
		else $error("ready right after a read request");

endmodule

bind sequenced_overwrite_ring_buffer_top sorb_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sorb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
